[rtl/core/udp_port_cpu_steering_table_assert.svh]
// Assertion macros used by the steering table checker.
`ifndef UDP_PORT_CPU_STEERING_TABLE_ASSERT_SVH
`define UDP_PORT_CPU_STEERING_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPCST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("steering table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UPCST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("steering table check failed");

`endif

[rtl/core/upcst_pkg.sv]
// Types and constants shared by the steering table modules.
`default_nettype none

package upcst_pkg;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  localparam logic [15:0] PORT_BASE_RST      = 16'd0;
  localparam logic [7:0]  DEFAULT_TARGET_RST = 8'd1;

  localparam logic [CFG_IDX_W-1:0] REG_PORT_BASE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TARGET = 1'b1;

  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_REGISTER   = 2'd1,
    OP_UNREGISTER = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic clear;    // write one reset entry and advance the sweep
    logic capture;  // latch the incoming word
    logic read;     // resolve the slot and read the table
    logic eval;     // finish the operation and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last; // sweep is at the last entry
    logic out_free; // result register can take a new word this cycle
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/upcst_ctrl.sv]
// Sequencing state machine of the steering table.
`default_nettype none

module upcst_ctrl
  import upcst_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output logic            s_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.capture = s_valid_i;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
      end
      ST_EVAL: begin
        cmd_o.eval = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/upcst_dpath.sv]
// Table memory, configuration registers and result logic of the steering table.
`default_nettype none

module upcst_dpath
  import upcst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output dp_status_t                 status_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire logic [IN_USER_W-1:0]  in_user_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [OUT_DATA_W-1:0]      out_data_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [16:0] DEPTH_17 = 17'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  // Each entry holds the enable bit above the stored CPU.
  logic [8:0] mem [TABLE_DEPTH];

  logic [15:0] port_base_q;
  logic [7:0]  default_target_q;

  logic [1:0]  opcode_q;
  logic [15:0] ethertype_q;
  logic [7:0]  proto_q;
  logic [15:0] port_q;
  logic [7:0]  new_target_q;

  logic [AW-1:0] clr_cnt_q;
  logic [AW-1:0] slot_q;
  logic          in_range_q;
  logic [8:0]    rd_q;

  logic          out_valid_q;
  logic [7:0]    out_target_q;
  logic          out_matched_q;
  logic          out_status_q;

  logic [16:0]   offset;
  logic          in_range_d;
  logic [AW-1:0] slot_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [8:0]    mem_wdata;

  logic          is_ipv4_udp;
  logic [7:0]    res_target;
  logic          res_matched;
  logic          res_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_base_q      <= PORT_BASE_RST;
      default_target_q <= DEFAULT_TARGET_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PORT_BASE:      port_base_q      <= cfg_data_i;
        REG_DEFAULT_TARGET: default_target_q <= cfg_data_i[7:0];
        default:            port_base_q      <= port_base_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q     <= in_user_i;
      ethertype_q  <= in_data_i[15:0];
      proto_q      <= in_data_i[23:16];
      port_q       <= in_data_i[39:24];
      new_target_q <= in_data_i[47:40];
    end
  end

  // True difference; a port below the base borrows into bit 16 and fails the compare.
  assign offset     = {1'b0, port_q} - {1'b0, port_base_q};
  assign in_range_d = (offset < DEPTH_17);
  assign slot_d     = offset[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      slot_q     <= slot_d;
      in_range_q <= in_range_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = {1'b1, new_target_q};
    if (cmd_i.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = {1'b1, 7'd0, clr_cnt_q[1]};
    end else if (cmd_i.eval && in_range_q) begin
      case (opcode_q)
        OP_REGISTER: begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, new_target_q};
        end
        OP_UNREGISTER: begin
          mem_we    = 1'b1;
          mem_wdata = {1'b0, default_target_q};
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.read) begin
      rd_q <= mem[slot_d];
    end
  end

  assign is_ipv4_udp = (ethertype_q == ETHERTYPE_IPV4) && (proto_q == PROTO_UDP);

  always_comb begin
    res_target  = 8'd0;
    res_matched = 1'b0;
    res_status  = 1'b0;
    case (opcode_q)
      OP_LOOKUP: begin
        if (is_ipv4_udp && in_range_q && rd_q[8]) begin
          res_target  = rd_q[7:0];
          res_matched = 1'b1;
        end else begin
          res_target = default_target_q;
        end
      end
      OP_REGISTER, OP_UNREGISTER: begin
        res_status = !in_range_q;
      end
      default: begin
        res_target = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.eval) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      out_target_q  <= res_target;
      out_matched_q <= res_matched;
      out_status_q  <= res_status;
    end
  end

  assign status_o.clr_last = (clr_cnt_q == LAST_IDX);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {6'd0, out_status_q, out_matched_q, out_target_q};

endmodule

`default_nettype wire

[rtl/core/udp_port_cpu_steering_table.sv]
// Top level of the UDP port CPU steering table.
`default_nettype none

// Receive-steering table that picks a target CPU for a packet from its UDP
// destination port. Each input word carries an operation in tuser: a lookup
// returns the CPU stored for the port when the packet is IPv4/UDP, the port
// lies in the window starting at port_base and the entry is enabled, and the
// default CPU otherwise; a register stores a CPU and enables the entry; an
// unregister disables the entry and stores the default CPU. Register and
// unregister report status 1 for a port outside the window. Every input word
// yields exactly one output word. After reset the block sweeps the whole
// table, one entry a cycle, and input is first accepted once the sweep is
// done; configuration writes are taken throughout. The word is latched at
// the edge that accepts it; the read state then forms the slot and reads
// the table, and the evaluate state writes the table back for a register
// or unregister in range and loads the result register. A new word is
// taken only after the previous one has left the evaluate state, and can be
// taken while a result still waits in the output register; the block
// waits in the evaluate state when a second result is ready before the
// first has been taken. Configuration registers are port_base (index 0)
// and default_target (index 1) and should only be written while no word is
// in flight.

module udp_port_cpu_steering_table
  import upcst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input words.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [15:0] ethertype, [23:16] ip_protocol, [39:24] udp_port, [47:40] new_target
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  // Result words.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [7:0] target_cpu, [8] matched, [9] status, [15:10] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // Configuration writes.
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  upcst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  upcst_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

[rtl/core/upcst_assert_checker.sv]
// Port-level checks of the steering table and their binding.
`default_nettype none

`include "udp_port_cpu_steering_table_assert.svh"

module upcst_assert_checker
  import upcst_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic       out_stall;
  logic [7:0] out_cpu;
  logic       out_hit;
  logic       out_err;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_cpu   = m_axis_tdata[7:0];
  assign out_hit   = m_axis_tdata[8];
  assign out_err   = m_axis_tdata[9];

  // A stalled result word holds its value.
  `UPCST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // A hit is only ever reported by a lookup, which never flags out of range.
  `UPCST_ASSERT_SAME(a_match_ok, clk_i, rst_ni, m_axis_tvalid && out_hit, !out_err)

  // Out-of-range status comes from register or unregister, which return CPU zero.
  `UPCST_ASSERT_SAME(a_status_zero, clk_i, rst_ni, m_axis_tvalid && out_err, out_cpu == 8'd0)

  // The spare upper bits of a result word are always zero.
  `UPCST_ASSERT_SAME(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[15:10] == 6'd0)

  // One word is worked on at a time: acceptance closes the input side.
  `UPCST_ASSERT_NEXT(a_one_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind udp_port_cpu_steering_table upcst_assert_checker u_assert_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[dv/udp_port_cpu_steering_table_tb.sv]
// Self-checking testbench for the UDP port CPU steering table.
`timescale 1ns / 1ps

module udp_port_cpu_steering_table_tb;
  import upcst_pkg::*;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 235;
  localparam int unsigned HOLD_CYCLES = 400;
  // Settling wait after draining: covers the read and evaluate states, with slack.
  localparam int unsigned SETTLE      = 8;

  // The fourth opcode is not part of the operation enum but is a legal word.
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86dd;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  // One descriptor as the sender sees it, before packing into tdata/tuser.
  typedef struct {
    logic [1:0]  op;
    logic [15:0] ethertype;
    logic [7:0]  proto;
    logic [15:0] port;
    logic [7:0]  cpu;
  } steer_req_t;

  // Laid out exactly as the result tdata, lowest field last in the list.
  typedef struct packed {
    logic [5:0] pad;
    logic       status;
    logic       matched;
    logic [7:0] target;
  } steer_verdict_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  udp_port_cpu_steering_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the steering state, kept in step with every accepted word.
  logic [7:0]  cpu_table [TABLE_DEPTH];
  bit          enable_map [TABLE_DEPTH];
  logic [15:0] port_base_m;
  logic [7:0]  default_cpu_m;

  steer_req_t     descriptor_q [$];
  steer_verdict_t cpu_verdict_q [$];

  int unsigned err_count     = 0;
  int unsigned items_taken   = 0;
  int unsigned words_checked = 0;
  int unsigned hit_count     = 0;
  int unsigned refused_count = 0;
  int unsigned reg_writes    = 0;

  // Set by the stimulus once the third random phase is queued; starts the long output stall.
  bit   stall_request = 1'b0;
  logic hold_off      = 1'b0;

  // Works out the result for one descriptor and applies its side effects to
  // the shadow table. The window test uses the true difference, so a port
  // below the base never wraps round into the table.
  function automatic steer_verdict_t resolve_steering(steer_req_t req);
    steer_verdict_t verdict;
    logic [16:0]    offset;
    bit             in_window;
    int unsigned    slot;
    verdict   = '0;
    offset    = {1'b0, req.port} - {1'b0, port_base_m};
    in_window = (req.port >= port_base_m) && (offset < TABLE_DEPTH);
    slot      = in_window ? int'(offset) : 0;
    case (req.op)
      OP_LOOKUP: begin
        verdict.target = default_cpu_m;
        if (req.ethertype == ETHERTYPE_IPV4 && req.proto == PROTO_UDP &&
            in_window && enable_map[slot]) begin
          verdict.target  = cpu_table[slot];
          verdict.matched = 1'b1;
          hit_count++;
        end
      end
      OP_REGISTER: begin
        if (in_window) begin
          cpu_table[slot]  = req.cpu;
          enable_map[slot] = 1'b1;
        end else begin
          verdict.status = 1'b1;
        end
      end
      OP_UNREGISTER: begin
        if (in_window) begin
          enable_map[slot] = 1'b0;
          cpu_table[slot]  = default_cpu_m;
        end else begin
          verdict.status = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (verdict.status) refused_count++;
    return verdict;
  endfunction

  task automatic queue_descriptor(logic [1:0] op, logic [15:0] ethertype, logic [7:0] proto,
                                  logic [15:0] port, logic [7:0] cpu);
    steer_req_t req;
    req.op        = op;
    req.ethertype = ethertype;
    req.proto     = proto;
    req.port      = port;
    req.cpu       = cpu;
    descriptor_q.push_back(req);
  endtask

  // Ports cluster on a few hot slots so that registrations are later looked
  // up, with the rest spread over the window, its edges and the whole space.
  function automatic logic [15:0] pick_port();
    int unsigned sel;
    logic [15:0] port;
    sel = $urandom_range(99);
    if (sel < 40) begin
      port = port_base_m + 16'($urandom_range(31));
    end else if (sel < 70) begin
      port = port_base_m + 16'($urandom_range(TABLE_DEPTH - 1));
    end else if (sel < 82) begin
      case ($urandom_range(3))
        0:       port = port_base_m - 16'd1;
        1:       port = port_base_m;
        2:       port = port_base_m + 16'(TABLE_DEPTH - 1);
        default: port = port_base_m + 16'(TABLE_DEPTH);
      endcase
    end else begin
      port = 16'($urandom_range(65535));
    end
    return port;
  endfunction

  task automatic queue_random_descriptor();
    int unsigned sel;
    logic [1:0]  op;
    logic [15:0] ethertype;
    logic [7:0]  proto;
    sel = $urandom_range(99);
    if (sel < 45)      op = OP_LOOKUP;
    else if (sel < 75) op = OP_REGISTER;
    else if (sel < 92) op = OP_UNREGISTER;
    else               op = OP_UNUSED;
    ethertype = ($urandom_range(99) < 85) ? ETHERTYPE_IPV4 : 16'($urandom_range(65535));
    proto     = ($urandom_range(99) < 85) ? PROTO_UDP : 8'($urandom_range(255));
    queue_descriptor(op, ethertype, proto, pick_port(), 8'($urandom_range(255)));
  endtask

  // Configuration writes are driven from the stimulus process only, and only
  // while no word is in flight, so the shadow copy is updated on acceptance.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == REG_PORT_BASE) port_base_m = data;
    else                        default_cpu_m = data[7:0];
    reg_writes++;
  endtask

  // Waits until every queued word has been taken and answered, then lets the
  // pipeline settle. Sampling at the falling edge keeps this free of races
  // with the driver and monitor, which act on the rising edge.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (descriptor_q.size() != 0 || s_axis_tvalid || cpu_verdict_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Sender: takes descriptors from the queue and offers them in bursts of
  // random length with random gaps, holding each word until it is accepted.
  // The expected result is formed at the edge where the word is taken.
  always @(posedge clk_i) begin : word_driver
    static steer_req_t  offered;
    static int unsigned burst_left = 1;
    static int unsigned gap_left   = 0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        cpu_verdict_q.push_back(resolve_steering(offered));
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (descriptor_q.size() != 0) begin
          offered = descriptor_q.pop_front();
          s_axis_tdata  <= {offered.cpu, offered.port, offered.proto, offered.ethertype};
          s_axis_tuser  <= offered.op;
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            // A quarter of the bursts run straight on with no gap at all.
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result word against the oldest expectation
  // and drives tready from a stall pattern that is picked anew at random.
  always @(posedge clk_i) begin : result_monitor
    static steer_verdict_t got;
    static steer_verdict_t want;
    static int unsigned    cycle_count = 0;
    static int unsigned    stall_mode  = 0;
    static logic           ready_next;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = steer_verdict_t'(m_axis_tdata);
        if (cpu_verdict_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("result word %h arrived with none expected", got);
        end else begin
          want = cpu_verdict_q.pop_front();
          words_checked++;
          if (got.target != want.target || got.matched != want.matched ||
              got.status != want.status || got.pad != want.pad) begin
            err_count++;
            if (err_count <= 10) begin
              $display("result word %0d: expected cpu %h matched %b status %b pad %h",
                       words_checked, want.target, want.matched, want.status, want.pad);
              $display("result word %0d: got      cpu %h matched %b status %b pad %h",
                       words_checked, got.target, got.matched, got.status, got.pad);
            end
          end
        end
      end
      cycle_count++;
      if (cycle_count % 50 == 0) stall_mode = $urandom_range(3);
      case (stall_mode)
        0:       ready_next = 1'b1;
        1:       ready_next = 1'($urandom_range(1));
        2:       ready_next = (cycle_count % 4 == 0);
        default: ready_next = ($urandom_range(9) != 0);
      endcase
      m_axis_tready <= ready_next && !hold_off;
    end
  end

  // Long output stall, counted here in cycles, while the sender keeps
  // offering words so that the block fills up and refuses input.
  initial begin
    wait (stall_request);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Main stimulus: reset, a directed pass over the corner cases, then random
  // phases with a fresh configuration each time the block has gone quiet.
  initial begin
    logic [15:0] base_pick;
    logic [15:0] default_pick;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cpu_table[i]  = 8'((i >> 1) & 1);
      enable_map[i] = 1'b1;
    end
    port_base_m   = PORT_BASE_RST;
    default_cpu_m = DEFAULT_TARGET_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: the table holds its power-up pattern and every
    // entry is enabled, so lookups in range hit straight away.
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'd0, 8'h00);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'd2, 8'hff);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'd4095, 8'h00);
    // A lookup outside the window keeps status clear and falls back.
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'd4096, 8'h00);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'hffff, 8'h00);
    // Packets that are not IPv4/UDP always get the default CPU.
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV6, PROTO_UDP, 16'd5, 8'h00);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_TCP, 16'd5, 8'h00);
    queue_descriptor(OP_LOOKUP, 16'hffff, 8'hff, 16'd5, 8'h00);
    // Register ignores the header fields; out of range is refused.
    queue_descriptor(OP_REGISTER, 16'hffff, 8'hff, 16'd10, 8'hff);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'd10, 8'h00);
    queue_descriptor(OP_REGISTER, ETHERTYPE_IPV4, PROTO_UDP, 16'd4096, 8'h55);
    queue_descriptor(OP_UNREGISTER, 16'h0000, 8'h00, 16'd10, 8'hff);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'd10, 8'h00);
    queue_descriptor(OP_UNREGISTER, ETHERTYPE_IPV4, PROTO_UDP, 16'hffff, 8'h00);
    // The spare opcode changes nothing, whatever the other fields carry.
    queue_descriptor(OP_UNUSED, ETHERTYPE_IPV4, PROTO_UDP, 16'd12, 8'hff);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'd12, 8'h00);
    queue_descriptor(OP_REGISTER, ETHERTYPE_IPV4, PROTO_UDP, 16'd4095, 8'h00);
    wait_drained();

    // Window at the very top of the port space; ports below it never wrap.
    // The default register is written with junk in its upper byte.
    write_reg(REG_PORT_BASE, 16'hffff);
    write_reg(REG_DEFAULT_TARGET, 16'hab00);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'hffff, 8'h00);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'd0, 8'h00);
    queue_descriptor(OP_REGISTER, ETHERTYPE_IPV4, PROTO_UDP, 16'd0, 8'h77);
    queue_descriptor(OP_REGISTER, ETHERTYPE_IPV4, PROTO_UDP, 16'hffff, 8'h5a);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'hffff, 8'h00);
    wait_drained();

    // Window whose last entry sits on the highest port.
    write_reg(REG_PORT_BASE, 16'(65536 - TABLE_DEPTH));
    write_reg(REG_DEFAULT_TARGET, 16'h00ff);
    queue_descriptor(OP_UNREGISTER, ETHERTYPE_IPV4, PROTO_UDP, 16'hffff, 8'h00);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'hffff, 8'h00);
    queue_descriptor(OP_LOOKUP, ETHERTYPE_IPV4, PROTO_UDP, 16'(65535 - TABLE_DEPTH), 8'h00);
    wait_drained();

    // Random phases. Every phase boundary is also a point where the sender
    // pauses until every expected result word has come back.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       base_pick = 16'd0;
        1:       base_pick = 16'hffff;
        2:       base_pick = 16'(65536 - TABLE_DEPTH);
        3:       base_pick = 16'd1;
        default: base_pick = 16'($urandom_range(65535));
      endcase
      case (p % 3)
        0:       default_pick = 16'($urandom_range(65535));
        1:       default_pick = 16'h00ff;
        default: default_pick = 16'h0000;
      endcase
      write_reg(REG_PORT_BASE, base_pick);
      write_reg(REG_DEFAULT_TARGET, default_pick);
      repeat (PHASE_ITEMS) queue_random_descriptor();
      if (p == 2) stall_request = 1'b1;
      wait_drained();
    end

    $display("covered %0d words in %0d result checks: %0d table hits, %0d refused ports",
             items_taken, words_checked, hit_count, refused_count);
    $display("register writes %0d over %0d random phases, one long output stall",
             reg_writes, PHASES);
    if (err_count == 0 && cpu_verdict_q.size() == 0) begin
      $display("udp_port_cpu_steering_table_tb: clean");
    end else begin
      $display("udp_port_cpu_steering_table_tb: errors");
    end
    $finish;
  end

  // Covers the table sweep after reset and the slowest stall patterns many
  // times over.
  initial begin
    #2_000_000;
    $display("timed out with %0d result words outstanding", cpu_verdict_q.size());
    $display("udp_port_cpu_steering_table_tb: errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/upcst_pkg.sv
rtl/core/upcst_ctrl.sv
rtl/core/upcst_dpath.sv
rtl/core/udp_port_cpu_steering_table.sv
rtl/core/upcst_assert_checker.sv
dv/udp_port_cpu_steering_table_tb.sv
